/* rtl/core/strb_pkg.sv */
// Shared types and constants of the scrambled trace ring buffer.
// No dependencies; imported by every module of the block except strb_fifo.
package strb_pkg;

   // field widths fixed by the interface
   localparam int SMP_W  = 16;
   localparam int TS_W   = 32;
   localparam int IDX_W  = 11;
   localparam int CAP_W  = 11;
   localparam int LEN_W  = 7;
   localparam int KEY_W  = 128;
   localparam int CSR_W  = 64;
   localparam int CSR_AW = 3;

   // queue depths between the parts
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_UNFILLED = 2'd1,
      STS_INVALID  = 2'd2,
      STS_TOO_LONG = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_PASS_LO  = 3'd0,
      CSR_PASS_HI  = 3'd1,
      CSR_SESS_LO  = 3'd2,
      CSR_SESS_HI  = 3'd3,
      CSR_CAPACITY = 3'd4
   } csr_index_type;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // back end sequencer states
   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_COPY  = 5'b00100,
      ST_RDHDR = 5'b01000,
      ST_READ  = 5'b10000
   } state_type;

   // classified command passed from front to back
   typedef struct packed {
      op_type           op;
      logic             has_sample;
      logic [SMP_W-1:0] sample_value;
      logic             last_sample;
      logic [TS_W-1:0]  timestamp_ms;
      logic [IDX_W-1:0] slot_index;
   } cmd_type;

   // one result item
   typedef struct packed {
      status_type       status;
      logic             is_read_data;
      logic             sample_present;
      logic [SMP_W-1:0] sample_out;
      logic [LEN_W-1:0] trace_length;
      logic [TS_W-1:0]  trace_time;
      logic             last_result;
   } rsp_type;

endpackage

/* rtl/core/strb_fifo.sv */
// Small register queue used between the front, the back and the result port.
// Depends on strb_pkg only through the importing modules; standalone logic.
module strb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [WIDTH-1:0]               wr_data,
   input  logic                           rd_en,
   output logic [WIDTH-1:0]               rd_data,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/strb_front.sv */
// Front end: takes request transfers, drops unused operation codes and
// queues classified commands for the back end. Uses strb_pkg and strb_fifo.
module strb_front import strb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_op,
   input  logic             req_has_sample,
   input  logic [SMP_W-1:0] req_sample_value,
   input  logic             req_last_sample,
   input  logic [TS_W-1:0]  req_timestamp_ms,
   input  logic [IDX_W-1:0] req_slot_index,
   output cmd_type          cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   cmd_type                          cmd_new;
   logic                             cmd_keep;
   logic                             q_empty;
   logic [$bits(cmd_type)-1:0]       q_rd_data;
   logic [$clog2(CMD_DEPTH+1)-1:0]   q_count;

   // classify: unused operation codes produce nothing
   always_comb begin
      cmd_new.op           = op_type'(req_op);
      cmd_new.has_sample   = req_has_sample;
      cmd_new.sample_value = req_sample_value;
      cmd_new.last_sample  = req_last_sample;
      cmd_new.timestamp_ms = req_timestamp_ms;
      cmd_new.slot_index   = req_slot_index;
      cmd_keep             = (cmd_new.op != OP_NONE);
   end

   strb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && cmd_keep),
      .wr_data (cmd_new),
      .rd_en   (cmd_pop),
      .rd_data (q_rd_data),
      .full    (full),
      .empty   (q_empty),
      .count   (q_count)
   );

   assign cmd       = cmd_type'(q_rd_data);
   assign cmd_valid = !q_empty && (q_count != '0);

endmodule

/* rtl/core/strb_back.sv */
// Back end: staging buffer, scrambled sample store, slot header memories and
// the sequencer that commits, reads and clears. Uses strb_pkg.
module strb_back import strb_pkg::*; #(
   parameter int MAX_SAMPLES  = 64,
   parameter int NUM_SLOTS    = 1024,
   parameter int HEADER_BYTES = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  logic             rsp_room,
   output logic             rsp_push,
   output rsp_type          rsp,
   input  logic [KEY_W-1:0] key,
   input  logic [CAP_W-1:0] cap
);

   localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PW        = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FW        = $clog2(MAX_SAMPLES + 1);
   localparam int DW        = SW + 1;
   localparam int MW        = $clog2(DW + 1);
   localparam int SB_MOD    = (HEADER_BYTES + 2 * MAX_SAMPLES) % 16;
   localparam int SMP_DEPTH = NUM_SLOTS * (1 << PW);

   // scramble mask for the sample at position p of slot s
   function automatic logic [SMP_W-1:0] smask(input logic [KEY_W-1:0] k,
                                              input logic [SW-1:0] s,
                                              input logic [PW-1:0] p);
      logic [3:0] b0;
      logic [3:0] b1;
      b0 = 4'(int'(4'(s)) * SB_MOD + 2 * int'(p));
      b1 = b0 + 4'd1;
      return {k[8*b1 +: 8], k[8*b0 +: 8]};
   endfunction

   // memories
   logic [SMP_W-1:0] stage_mem [MAX_SAMPLES];
   logic [SMP_W-1:0] smp_mem   [SMP_DEPTH];
   logic             vld_mem   [NUM_SLOTS];
   logic [FW-1:0]    len_mem   [NUM_SLOTS];
   logic [TS_W-1:0]  time_mem  [NUM_SLOTS];

   logic [SMP_W-1:0] stage_q_ff;
   logic [SMP_W-1:0] smp_q_ff;
   logic             vld_q_ff;
   logic [FW-1:0]    len_q_ff;
   logic [TS_W-1:0]  time_q_ff;

   // memory port controls
   logic             stage_we;
   logic [PW-1:0]    stage_wa, stage_ra;
   logic             smp_we;
   logic [SW+PW-1:0] smp_wa, smp_ra;
   logic [SMP_W-1:0] smp_wd;
   logic             info_we;
   logic [SW-1:0]    info_wa, info_ra;
   logic             vld_wd;
   logic [FW-1:0]    len_wd;
   logic [TS_W-1:0]  time_wd;

   // sequencer registers
   state_type        state_ff, state_in;
   logic [SW-1:0]    sweep_ff, sweep_in;
   logic [SW-1:0]    ws_ff, ws_in;
   logic [CAP_W-1:0] filled_ff, filled_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             ovf_ff, ovf_in;
   logic [FW-1:0]    clen_ff, clen_in;
   logic [TS_W-1:0]  cts_ff, cts_in;
   logic [FW-1:0]    cp_cnt_ff, cp_cnt_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [PW-1:0]    wr_pos_ff, wr_pos_in;
   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [MW-1:0]    mcnt_ff, mcnt_in;
   logic [SW-1:0]    rd_slot_ff, rd_slot_in;
   logic [FW-1:0]    rd_len_ff, rd_len_in;
   logic [TS_W-1:0]  rd_time_ff, rd_time_in;
   logic [FW-1:0]    iss_ff, iss_in;
   logic             pend_ff, pend_in;
   logic [PW-1:0]    pend_pos_ff, pend_pos_in;

   // sequencer
   always_comb begin
      logic             over;
      logic             ovf_now;
      logic [FW-1:0]    fill_nx;
      logic [CAP_W:0]   shifted;
      logic [FW-1:0]    hdr_len;

      state_in    = state_ff;
      sweep_in    = sweep_ff;
      ws_in       = ws_ff;
      filled_in   = filled_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      clen_in     = clen_ff;
      cts_in      = cts_ff;
      cp_cnt_in   = cp_cnt_ff;
      wr_pend_in  = wr_pend_ff;
      wr_pos_in   = wr_pos_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      mcnt_in     = mcnt_ff;
      rd_slot_in  = rd_slot_ff;
      rd_len_in   = rd_len_ff;
      rd_time_in  = rd_time_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;

      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp      = '0;
      rsp.status = STS_OK;

      stage_we = 1'b0;
      stage_wa = fill_ff[PW-1:0];
      stage_ra = cp_cnt_ff[PW-1:0];
      smp_we   = 1'b0;
      smp_wa   = {ws_ff, wr_pos_ff};
      smp_wd   = stage_q_ff ^ smask(key, ws_ff, wr_pos_ff);
      smp_ra   = {rd_slot_ff, iss_ff[PW-1:0]};
      info_we  = 1'b0;
      info_wa  = ws_ff;
      info_ra  = SW'(cmd.slot_index);
      vld_wd   = 1'b0;
      len_wd   = clen_ff;
      time_wd  = cts_ff;

      over    = cmd.has_sample && (fill_ff >= FW'(MAX_SAMPLES));
      ovf_now = ovf_ff || over;
      fill_nx = (cmd.has_sample && !over) ? fill_ff + 1'b1 : fill_ff;
      shifted = {rem_ff, div_ff[DW-1]};
      hdr_len = (len_q_ff > FW'(MAX_SAMPLES)) ? FW'(MAX_SAMPLES) : len_q_ff;

      case (state_ff)
         // invalidate every slot, one per cycle
         ST_SWEEP: begin
            info_we  = 1'b1;
            info_wa  = sweep_ff;
            vld_wd   = 1'b0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SW'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // dispatch one command
         ST_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_PUSH: begin
                     stage_we         = cmd.has_sample && !over;
                     fill_in          = fill_nx;
                     ovf_in           = ovf_now;
                     rsp_push         = 1'b1;
                     rsp.status       = ovf_now ? STS_TOO_LONG : STS_OK;
                     rsp.last_result  = cmd.last_sample;
                     if (cmd.last_sample) begin
                        fill_in = '0;
                        ovf_in  = 1'b0;
                        if (!ovf_now) begin
                           clen_in    = fill_nx;
                           cts_in     = cmd.timestamp_ms;
                           cp_cnt_in  = '0;
                           wr_pend_in = 1'b0;
                           rem_in     = '0;
                           div_in     = DW'(ws_ff) + 1'b1;
                           mcnt_in    = MW'(DW);
                           state_in   = ST_COPY;
                        end
                     end
                  end
                  OP_READ: begin
                     if ((cmd.slot_index >= filled_ff) ||
                         (32'(cmd.slot_index) >= NUM_SLOTS)) begin
                        rsp_push         = 1'b1;
                        rsp.status       = STS_UNFILLED;
                        rsp.is_read_data = 1'b1;
                        rsp.last_result  = 1'b1;
                     end else begin
                        rd_slot_in = SW'(cmd.slot_index);
                        smp_ra     = {SW'(cmd.slot_index), PW'(0)};
                        state_in   = ST_RDHDR;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_push        = 1'b1;
                     rsp.last_result = 1'b1;
                     ws_in           = '0;
                     filled_in       = '0;
                     fill_in         = '0;
                     ovf_in          = 1'b0;
                     sweep_in        = '0;
                     state_in        = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // copy staged samples into the slot, next write slot by remainder
         ST_COPY: begin
            if (cp_cnt_ff < clen_ff) begin
               cp_cnt_in  = cp_cnt_ff + 1'b1;
               wr_pend_in = 1'b1;
               wr_pos_in  = cp_cnt_ff[PW-1:0];
            end else begin
               wr_pend_in = 1'b0;
            end
            smp_we = wr_pend_ff;
            if (mcnt_ff != '0) begin
               div_in  = {div_ff[DW-2:0], 1'b0};
               mcnt_in = mcnt_ff - 1'b1;
               if (shifted >= {1'b0, cap}) begin
                  rem_in = CAP_W'(shifted - {1'b0, cap});
               end else begin
                  rem_in = CAP_W'(shifted);
               end
            end
            if ((cp_cnt_ff == clen_ff) && !wr_pend_ff && (mcnt_ff == '0)) begin
               info_we  = 1'b1;
               vld_wd   = 1'b1;
               ws_in    = SW'(rem_ff);
               if (filled_ff < cap) begin
                  filled_in = filled_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         // slot header and first sample are back from memory
         ST_RDHDR: begin
            rsp_push         = 1'b1;
            rsp.is_read_data = 1'b1;
            rsp.last_result  = 1'b1;
            state_in         = ST_IDLE;
            if (!vld_q_ff) begin
               rsp.status = STS_INVALID;
            end else begin
               rsp.trace_time   = time_q_ff;
               rsp.trace_length = LEN_W'(hdr_len);
               if (hdr_len != '0) begin
                  rsp.sample_present = 1'b1;
                  rsp.sample_out     = smp_q_ff ^ smask(key, rd_slot_ff, PW'(0));
                  rd_len_in          = hdr_len;
                  rd_time_in         = time_q_ff;
                  if (hdr_len != FW'(1)) begin
                     rsp.last_result = 1'b0;
                     smp_ra          = {rd_slot_ff, PW'(1)};
                     pend_in         = 1'b1;
                     pend_pos_in     = PW'(1);
                     iss_in          = FW'(2);
                     state_in        = ST_READ;
                  end
               end
            end
         end

         // stream the remaining samples
         ST_READ: begin
            if (pend_ff) begin
               rsp_push           = 1'b1;
               rsp.is_read_data   = 1'b1;
               rsp.sample_present = 1'b1;
               rsp.sample_out     = smp_q_ff ^ smask(key, rd_slot_ff, pend_pos_ff);
               rsp.trace_length   = LEN_W'(rd_len_ff);
               rsp.trace_time     = rd_time_ff;
               if (FW'(pend_pos_ff) == rd_len_ff - FW'(1)) begin
                  rsp.last_result = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
            if ((iss_ff < rd_len_ff) && rsp_room) begin
               pend_in     = 1'b1;
               pend_pos_in = iss_ff[PW-1:0];
               iss_in      = iss_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end

         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         sweep_ff   <= '0;
         ws_ff      <= '0;
         filled_ff  <= '0;
         fill_ff    <= '0;
         ovf_ff     <= 1'b0;
         cp_cnt_ff  <= '0;
         wr_pend_ff <= 1'b0;
         mcnt_ff    <= '0;
         iss_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         ws_ff      <= ws_in;
         filled_ff  <= filled_in;
         fill_ff    <= fill_in;
         ovf_ff     <= ovf_in;
         cp_cnt_ff  <= cp_cnt_in;
         wr_pend_ff <= wr_pend_in;
         mcnt_ff    <= mcnt_in;
         iss_ff     <= iss_in;
         pend_ff    <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      clen_ff     <= clen_in;
      cts_ff      <= cts_in;
      wr_pos_ff   <= wr_pos_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      rd_slot_ff  <= rd_slot_in;
      rd_len_ff   <= rd_len_in;
      rd_time_ff  <= rd_time_in;
      pend_pos_ff <= pend_pos_in;
   end

   // staging buffer
   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[stage_wa] <= cmd.sample_value;
      end
      stage_q_ff <= stage_mem[stage_ra];
   end

   // scrambled sample store
   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_wa] <= smp_wd;
      end
      smp_q_ff <= smp_mem[smp_ra];
   end

   // slot headers
   always_ff @(posedge clock) begin
      if (info_we) begin
         vld_mem[info_wa]  <= vld_wd;
         len_mem[info_wa]  <= len_wd;
         time_mem[info_wa] <= time_wd;
      end
      vld_q_ff  <= vld_mem[info_ra];
      len_q_ff  <= len_mem[info_ra];
      time_q_ff <= time_mem[info_ra];
   end

endmodule

/* rtl/core/scrambled_trace_ring_buffer.sv */
// Top level of the scrambled trace ring buffer: configuration registers,
// key forming, front end, back end and result queue. Uses strb_pkg.
//
// A ring of trace slots holding scrambled 16-bit samples. After reset, and
// after every clear command, the slot valid marks are swept one slot per
// cycle, during which the back end takes no command from the request queue
// (configuration writes are still taken). Push items that do not end a trace,
// too-long traces and reads of unfilled slots are answered in the idle state;
// a clear starts the sweep. A push that ends a trace copies the staged samples
// into the sample store one per cycle and in parallel finds the next write slot
// with a bit-serial remainder, holding the back end until both are done. A read
// fetches the slot header and first sample, then streams one sample per cycle
// while the result queue has room, set by the single read port of the sample
// store. Results wait in a four-deep queue; requests wait in a two-deep queue.
module scrambled_trace_ring_buffer import strb_pkg::*; #(
   parameter int MAX_SAMPLES   = 64,
   parameter int NUM_SLOTS     = 1024,
   parameter int SESSION_BYTES = 16,
   parameter int HEADER_BYTES  = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   // request queue side
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_op,
   input  logic                     req_has_sample,
   input  logic signed [SMP_W-1:0]  req_sample_value,
   input  logic                     req_last_sample,
   input  logic [TS_W-1:0]          req_timestamp_ms,
   input  logic [IDX_W-1:0]         req_slot_index,
   // result queue side
   output logic                     empty,
   input  logic                     pop,
   output logic [1:0]               rsp_status,
   output logic                     rsp_is_read_data,
   output logic                     rsp_sample_present,
   output logic signed [SMP_W-1:0]  rsp_sample_out,
   output logic [LEN_W-1:0]         rsp_trace_length,
   output logic [TS_W-1:0]          rsp_trace_time,
   output logic                     rsp_last_result,
   // configuration write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_AW-1:0]        csr_index,
   input  logic [CSR_W-1:0]         csr_data
);

   logic [CSR_W-1:0] pass_lo_ff, pass_hi_ff, sess_lo_ff, sess_hi_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_eff;
   logic [KEY_W-1:0] pass_vec, sess_vec, key;

   cmd_type          cmd;
   logic             cmd_valid, cmd_pop;
   logic             rsp_push, rsp_room;
   rsp_type          rsp_new, rsp_head;
   logic [$bits(rsp_type)-1:0]     rsp_rd_data;
   logic                           rsp_full;
   logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_lo_ff <= '0;
         pass_hi_ff <= '0;
         sess_lo_ff <= '0;
         sess_hi_ff <= '0;
         cap_ff     <= CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PASS_LO:  pass_lo_ff <= csr_data;
            CSR_PASS_HI:  pass_hi_ff <= csr_data;
            CSR_SESS_LO:  sess_lo_ff <= csr_data;
            CSR_SESS_HI:  sess_hi_ff <= csr_data;
            CSR_CAPACITY: cap_ff     <= CAP_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // capacity clamped to one through NUM_SLOTS
   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(cap_ff) > NUM_SLOTS) begin
         cap_eff = CAP_W'(NUM_SLOTS);
      end
   end

   // key byte i is passkey byte i xor session byte i mod SESSION_BYTES
   assign pass_vec = {pass_hi_ff, pass_lo_ff};
   assign sess_vec = {sess_hi_ff, sess_lo_ff};

   for (genvar i = 0; i < 16; i++) begin : g_key
      localparam int SI = i % SESSION_BYTES;
      assign key[8*i +: 8] = pass_vec[8*i +: 8] ^ sess_vec[8*SI +: 8];
   end

   strb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_has_sample   (req_has_sample),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .req_timestamp_ms (req_timestamp_ms),
      .req_slot_index   (req_slot_index),
      .cmd              (cmd),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop)
   );

   // room for the result being made plus one read in flight
   assign rsp_room = (rsp_count <= ($clog2(RSP_DEPTH+1))'(RSP_DEPTH - 2));

   strb_back #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .NUM_SLOTS    (NUM_SLOTS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp       (rsp_new),
      .key       (key),
      .cap       (cap_eff)
   );

   strb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_new),
      .rd_en   (pop),
      .rd_data (rsp_rd_data),
      .full    (rsp_full),
      .empty   (empty),
      .count   (rsp_count)
   );

   // result ports
   assign rsp_head           = rsp_type'(rsp_rd_data);
   assign rsp_status         = rsp_head.status;
   assign rsp_is_read_data   = rsp_head.is_read_data;
   assign rsp_sample_present = rsp_head.sample_present;
   assign rsp_sample_out     = rsp_head.sample_out;
   assign rsp_trace_length   = rsp_head.trace_length;
   assign rsp_trace_time     = rsp_head.trace_time;
   assign rsp_last_result    = rsp_head.last_result;

endmodule

/* test/scrambled_trace_ring_buffer_checker.sv */
// Checker of the scrambled trace ring buffer test: mirrors the ring state,
// predicts every result and compares the popped ones. Uses strb_pkg.
module scrambled_trace_ring_buffer_checker import strb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic [1:0]        req_op,
   input  logic              req_has_sample,
   input  logic [SMP_W-1:0]  req_sample_value,
   input  logic              req_last_sample,
   input  logic [TS_W-1:0]   req_timestamp_ms,
   input  logic [IDX_W-1:0]  req_slot_index,
   input  logic              empty,
   input  logic              pop,
   input  logic [1:0]        rsp_status,
   input  logic              rsp_is_read_data,
   input  logic              rsp_sample_present,
   input  logic [SMP_W-1:0]  rsp_sample_out,
   input  logic [LEN_W-1:0]  rsp_trace_length,
   input  logic [TS_W-1:0]   rsp_trace_time,
   input  logic              rsp_last_result,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   output int                error_count,
   output int                pending
);

   localparam int MAX_SAMPLES = 64;
   localparam int NUM_SLOTS   = 1024;
   localparam int SLOT_BYTES  = 12 + 2 * MAX_SAMPLES;

   // mirrored configuration
   logic [63:0]      pass_lo, pass_hi, sess_lo, sess_hi;
   logic [CAP_W-1:0] cap_reg;

   // mirrored ring
   logic [SMP_W-1:0] ring_store [0:NUM_SLOTS*MAX_SAMPLES-1];
   logic [LEN_W-1:0] ring_len   [0:NUM_SLOTS-1];
   logic [TS_W-1:0]  ring_time  [0:NUM_SLOTS-1];
   bit               ring_valid [0:NUM_SLOTS-1];
   logic [SMP_W-1:0] staging    [0:MAX_SAMPLES-1];
   int               wr_slot, filled, fill_pos;
   bit               overflow;

   rsp_type          expected_rsps [$];

   function automatic logic [7:0] key_byte(int i);
      logic [7:0] pb, sb;
      i = i & 15;
      pb = (i < 8) ? pass_lo[8*i +: 8] : pass_hi[8*(i-8) +: 8];
      sb = (i < 8) ? sess_lo[8*i +: 8] : sess_hi[8*(i-8) +: 8];
      return pb ^ sb;
   endfunction

   function automatic logic [15:0] slot_mask(int s, int p);
      int b;
      b = s * SLOT_BYTES + 2 * p;
      return {key_byte(b + 1), key_byte(b)};
   endfunction

   function automatic void add_rsp(status_type st, bit rd, bit sp, logic [15:0] v,
                                   logic [LEN_W-1:0] len, logic [31:0] tm, bit lst);
      rsp_type r;
      r.status = st;
      r.is_read_data = rd;
      r.sample_present = sp;
      r.sample_out = v;
      r.trace_length = len;
      r.trace_time = tm;
      r.last_result = lst;
      expected_rsps.push_back(r);
   endfunction

   // effect of one accepted request on the ring, with its results
   function automatic void predict_request();
      int cap, idx, len;
      idx = req_slot_index;
      case (req_op)
         OP_PUSH: begin
            if (req_has_sample) begin
               if (fill_pos < MAX_SAMPLES) begin
                  staging[fill_pos] = req_sample_value;
                  fill_pos++;
               end else begin
                  overflow = 1;
               end
            end
            if (!req_last_sample) begin
               add_rsp(overflow ? STS_TOO_LONG : STS_OK, 0, 0, 0, 0, 0, 0);
            end else begin
               if (overflow) begin
                  add_rsp(STS_TOO_LONG, 0, 0, 0, 0, 0, 1);
               end else begin
                  cap = cap_reg;
                  if (cap == 0) cap = 1;
                  if (cap > NUM_SLOTS) cap = NUM_SLOTS;
                  for (int p = 0; p < fill_pos; p++)
                     ring_store[wr_slot*MAX_SAMPLES + p] = staging[p] ^ slot_mask(wr_slot, p);
                  ring_len[wr_slot] = LEN_W'(fill_pos);
                  ring_time[wr_slot] = req_timestamp_ms;
                  ring_valid[wr_slot] = 1;
                  wr_slot = (wr_slot + 1) % cap;
                  if (filled < cap) filled++;
                  add_rsp(STS_OK, 0, 0, 0, 0, 0, 1);
               end
               fill_pos = 0;
               overflow = 0;
            end
         end
         OP_READ: begin
            if (idx >= filled || idx >= NUM_SLOTS) begin
               add_rsp(STS_UNFILLED, 1, 0, 0, 0, 0, 1);
            end else if (!ring_valid[idx]) begin
               add_rsp(STS_INVALID, 1, 0, 0, 0, 0, 1);
            end else begin
               len = ring_len[idx];
               if (len > MAX_SAMPLES) len = MAX_SAMPLES;
               if (len == 0)
                  add_rsp(STS_OK, 1, 0, 0, 0, ring_time[idx], 1);
               for (int p = 0; p < len; p++)
                  add_rsp(STS_OK, 1, 1, ring_store[idx*MAX_SAMPLES + p] ^ slot_mask(idx, p),
                          LEN_W'(len), ring_time[idx], p + 1 == len);
            end
         end
         OP_CLEAR: begin
            for (int s = 0; s < NUM_SLOTS; s++) ring_valid[s] = 0;
            wr_slot = 0;
            filled = 0;
            fill_pos = 0;
            overflow = 0;
            add_rsp(STS_OK, 0, 0, 0, 0, 0, 1);
         end
         default: ;
      endcase
   endfunction

   // compare, predict and track configuration on each edge
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         pass_lo = 0; pass_hi = 0; sess_lo = 0; sess_hi = 0;
         cap_reg = CAP_RESET;
         for (int s = 0; s < NUM_SLOTS; s++) ring_valid[s] = 0;
         wr_slot = 0; filled = 0; fill_pos = 0; overflow = 0;
         expected_rsps.delete();
         error_count = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $error("result transfer with no expected result");
               error_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $error("status expected %0d got %0d", exp_rsp.status, rsp_status);
                  error_count++;
               end
               if (rsp_is_read_data !== exp_rsp.is_read_data) begin
                  $error("is_read_data expected %0d got %0d",
                         exp_rsp.is_read_data, rsp_is_read_data);
                  error_count++;
               end
               if (rsp_sample_present !== exp_rsp.sample_present) begin
                  $error("sample_present expected %0d got %0d",
                         exp_rsp.sample_present, rsp_sample_present);
                  error_count++;
               end
               if (rsp_sample_out !== exp_rsp.sample_out) begin
                  $error("sample_out expected %h got %h", exp_rsp.sample_out, rsp_sample_out);
                  error_count++;
               end
               if (rsp_trace_length !== exp_rsp.trace_length) begin
                  $error("trace_length expected %0d got %0d",
                         exp_rsp.trace_length, rsp_trace_length);
                  error_count++;
               end
               if (rsp_trace_time !== exp_rsp.trace_time) begin
                  $error("trace_time expected %h got %h", exp_rsp.trace_time, rsp_trace_time);
                  error_count++;
               end
               if (rsp_last_result !== exp_rsp.last_result) begin
                  $error("last_result expected %0d got %0d",
                         exp_rsp.last_result, rsp_last_result);
                  error_count++;
               end
            end
         end
         if (push && !full)
            predict_request();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PASS_LO:  pass_lo = csr_data;
               CSR_PASS_HI:  pass_hi = csr_data;
               CSR_SESS_LO:  sess_lo = csr_data;
               CSR_SESS_HI:  sess_hi = csr_data;
               CSR_CAPACITY: cap_reg = csr_data[CAP_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_rsps.size();
   end

endmodule

/* test/scrambled_trace_ring_buffer_test.sv */
// Top of the scrambled trace ring buffer test: clock, reset, stimulus,
// result stalls and verdict. Uses strb_pkg and the checker module.
module scrambled_trace_ring_buffer_test;
   import strb_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;

   logic              clock = 0;
   logic              reset = 1;
   logic              push = 0;
   logic              full;
   logic [1:0]        req_op = OP_NONE;
   logic              req_has_sample = 0;
   logic [SMP_W-1:0]  req_sample_value = 0;
   logic              req_last_sample = 0;
   logic [TS_W-1:0]   req_timestamp_ms = 0;
   logic [IDX_W-1:0]  req_slot_index = 0;
   logic              empty;
   logic              pop = 0;
   logic [1:0]        rsp_status;
   logic              rsp_is_read_data;
   logic              rsp_sample_present;
   logic [SMP_W-1:0]  rsp_sample_out;
   logic [LEN_W-1:0]  rsp_trace_length;
   logic [TS_W-1:0]   rsp_trace_time;
   logic              rsp_last_result;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index = 0;
   logic [CSR_W-1:0]  csr_data = 0;
   int                error_count;
   int                pending;

   int                burst_left = 0;
   int                items_sent = 0;
   int                idle_cycles = 0;
   int                stall_mode = 0;

   scrambled_trace_ring_buffer dut (.*);

   scrambled_trace_ring_buffer_checker checker_i (.*);

   always #10 clock = ~clock;

   // result side stalls, pattern picked anew at random times
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: pop <= 1;
         1: pop <= $urandom_range(0, 1);
         2: pop <= ($urandom_range(0, 3) == 0);
         default: pop <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("scrambled_trace_ring_buffer_test NOT OK");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      push <= 0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic send_item(op_type op, bit has, logic [15:0] v, bit is_last,
                            logic [31:0] ts, logic [10:0] idx);
      if (burst_left == 0) begin
         push <= 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      push <= 1;
      req_op <= op;
      req_has_sample <= has;
      req_sample_value <= v;
      req_last_sample <= is_last;
      req_timestamp_ms <= ts;
      req_slot_index <= idx;
      while (full) @(negedge clock);
      @(negedge clock);
      if (op != OP_NONE) items_sent++;
   endtask

   // one trace of n items, random content
   task automatic send_trace(int n);
      for (int k = 0; k < n; k++)
         send_item(OP_PUSH, $urandom_range(0, 7) != 0, $urandom, k == n - 1,
                   $urandom, $urandom);
   endtask

   task automatic configure(logic [63:0] key_val, logic [10:0] cap);
      wait_idle();
      write_reg(CSR_PASS_LO, key_val);
      write_reg(CSR_PASS_HI, {$urandom, $urandom});
      write_reg(CSR_SESS_LO, {$urandom, $urandom});
      write_reg(CSR_SESS_HI, ~key_val);
      write_reg(CSR_CAPACITY, cap);
   endtask

   initial begin
      int r;
      int n;
      logic [10:0] caps [6];
      caps = '{11'd1, 11'd3, 11'd0, 11'd2047, 11'd1024, 11'd17};
      repeat (7) @(negedge clock);
      reset <= 0;

      // directed part
      configure(64'h0123_4567_89AB_CDEF, 11'd1024);
      send_item(OP_READ, 0, 0, 0, 0, 11'd0);
      send_item(OP_PUSH, 1, 16'h8000, 0, 0, 0);
      send_item(OP_PUSH, 1, 16'h7FFF, 0, 0, 0);
      send_item(OP_PUSH, 0, 16'hFFFF, 0, 0, 0);
      send_item(OP_PUSH, 1, 16'h5A5A, 1, 32'hFFFF_FFFF, 11'h7FF);
      send_item(OP_PUSH, 0, 0, 1, 32'h0, 0);
      send_item(OP_NONE, 1, 16'h1234, 1, 32'h55AA, 11'd0);
      send_item(OP_READ, 0, 0, 0, 0, 11'd0);
      send_item(OP_READ, 0, 0, 0, 0, 11'd1);
      send_item(OP_READ, 0, 0, 0, 0, 11'd2);
      send_item(OP_READ, 0, 0, 0, 0, 11'd1024);
      send_item(OP_READ, 0, 0, 0, 0, 11'h7FF);
      send_trace(65);
      send_trace(64);
      send_item(OP_READ, 0, 0, 0, 0, 11'd2);
      send_item(OP_PUSH, 1, 16'h0001, 0, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0, 0, 0);
      send_item(OP_READ, 0, 0, 0, 0, 11'd0);

      // key read back under a different key
      configure(64'hFFFF_FFFF_FFFF_FFFF, 11'd1024);
      send_trace(3);
      send_item(OP_READ, 0, 0, 0, 0, 11'd0);
      configure(64'h0, 11'd1024);
      send_item(OP_READ, 0, 0, 0, 0, 11'd0);

      // random phases over capacities and keys
      for (int ph = 0; items_sent < 260; ph++) begin
         configure({$urandom, $urandom}, caps[ph % 6]);
         for (int k = 0; k < 20; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               r = $urandom_range(0, 99);
               n = (r < 70) ? $urandom_range(1, 6) : (r < 88) ? $urandom_range(7, 20) :
                   (r < 96) ? $urandom_range(60, 64) : $urandom_range(65, 68);
               send_trace(n);
            end else if (r < 85) begin
               send_item(OP_READ, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20));
            end else if (r < 90) begin
               send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 93) begin
               send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
               // unfinished trace left to later items
               send_item(OP_PUSH, 1, $urandom, 0, $urandom, $urandom);
            end
         end
      end

      // drain
      push <= 0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (error_count == 0)
         $display("scrambled_trace_ring_buffer_test OK");
      else
         $display("scrambled_trace_ring_buffer_test NOT OK");
      $finish;
   end

endmodule
